// File: rtl/core/smh64_pkg.sv
// Package for the streaming 64-bit mixed hash: widths, mixing constants,
// step and phase codes, and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package smh64_pkg;

  // field widths
  localparam int WordW   = 64;
  localparam int NbW     = 4;
  localparam int MsgLenW = 32;
  localparam int HalfW   = 32;

  // message length is masked to this many bits
  localparam int LenBits = 32;
  localparam int LenKeep = (LenBits < MsgLenW) ? LenBits : MsgLenW;
  localparam logic [MsgLenW-1:0] LenMask =
    MsgLenW'((65'd1 << LenKeep) - 65'd1);

  // mixing constants
  localparam logic [WordW-1:0] Golden = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixC1  = 64'hff51afd7ed558ccd;
  localparam logic [WordW-1:0] MixC2  = 64'hc4ceb9fe1a85ec53;
  localparam int ShiftMix = 33;

  // bytes in a full word
  localparam logic [NbW-1:0] FullBytes = 4'd8;

  // partial product steps of one 64x64 (low half) multiply
  localparam logic [1:0] StepLL = 2'd0;  // a_lo * b_lo
  localparam logic [1:0] StepLH = 2'd1;  // a_lo * b_hi, upper half
  localparam logic [1:0] StepHL = 2'd2;  // a_hi * b_lo, upper half, write-back

  // which multiply the datapath is working on
  typedef enum logic [1:0] {
    PhInit,  // length * golden, seeds the hash
    PhKey,   // word * C1
    PhHash,  // hash * C2
    PhFin    // finaliser multiply by C1
  } phase_e;

  typedef struct packed {
    logic       load;     // latch input word
    logic       mul_en;   // run one multiply step
    logic [1:0] step;
    phase_e     phase;
  } dp_cmd_t;

  typedef struct packed {
    logic in_nbz;     // incoming word carries no bytes
    logic in_last;    // incoming word ends its message
    logic nbz;        // latched word carries no bytes
    logic last;       // latched word ends its message
    logic out_valid;  // result register occupied
  } dp_sts_t;

endpackage

// File: rtl/core/smh64_in_if.sv
// Input channel of the hash block: valid/ready handshake and one message word.
// Depends on smh64_pkg.
`timescale 1ns / 1ps

interface smh64_in_if;
  logic                            valid;
  logic                            ready;
  logic [smh64_pkg::WordW-1:0]     data_word;
  logic [smh64_pkg::NbW-1:0]       valid_bytes;
  logic                            last_word;
  logic [smh64_pkg::MsgLenW-1:0]   message_length;

  modport source (
    output valid, data_word, valid_bytes, last_word, message_length,
    input  ready
  );
  modport sink (
    input  valid, data_word, valid_bytes, last_word, message_length,
    output ready
  );
endinterface

// File: rtl/core/smh64_out_if.sv
// Output channel of the hash block: valid/ready handshake and the 64-bit hash.
// Depends on smh64_pkg.
`timescale 1ns / 1ps

interface smh64_out_if;
  logic                        valid;
  logic                        ready;
  logic [smh64_pkg::WordW-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// File: rtl/core/streaming_mixed_hash64.sv
// Top level of the streaming 64-bit mixed hash: controller plus datapath.
// Depends on smh64_pkg, smh64_in_if, smh64_out_if, smh64_ctrl, smh64_dp.
//
// Usage:
//   in_i carries one message word at a time (data_word, valid_bytes,
//   last_word, message_length); a word is taken when valid and ready are
//   both high. message_length is read on the first word of each message.
//   out_o carries one hash_value word per message, after its last word.
//   The seed is written through cfg_we_i/cfg_wdata_i while the block is idle;
//   the block itself does not enforce this. All 64-bit multiplies run on one
//   shared 32x32 multiplier, as the partial product steps LL, LH and HL, and
//   a word takes 0 to 4 multiplies: one to seed a first word, two to mix a
//   non-empty word, one for the finaliser on a last word. A new word is taken
//   only while the block is idle, once every multiply of the last word is done.
//   Reset clears the seed to zero and waits for the first word of a message.
//   The result sits in an output register; the next words are accepted
//   while it waits, and only the next finaliser holds until it is taken.
`timescale 1ns / 1ps

module streaming_mixed_hash64 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  smh64_in_if.sink                    in_i,
  smh64_out_if.source                 out_o,
  input  logic                        cfg_we_i,
  input  logic [smh64_pkg::WordW-1:0] cfg_wdata_i
);

  smh64_pkg::dp_cmd_t cmd;
  smh64_pkg::dp_sts_t sts;
  logic               in_ready;

  assign in_i.ready = in_ready;

  smh64_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smh64_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .data_word_i      (in_i.data_word),
    .valid_bytes_i    (in_i.valid_bytes),
    .last_word_i      (in_i.last_word),
    .message_length_i (in_i.message_length),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .hash_o           (out_o.hash_value)
  );

endmodule

// File: rtl/core/smh64_dp.sv
// Datapath of the hash block: seed register, latched word, running hash,
// one shared 32x32 multiplier with its accumulator, and the result register.
// Depends on smh64_pkg.
`timescale 1ns / 1ps

module smh64_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smh64_pkg::WordW-1:0]     cfg_wdata_i,
  input  logic [smh64_pkg::WordW-1:0]     data_word_i,
  input  logic [smh64_pkg::NbW-1:0]       valid_bytes_i,
  input  logic                            last_word_i,
  input  logic [smh64_pkg::MsgLenW-1:0]   message_length_i,
  input  smh64_pkg::dp_cmd_t              cmd_i,
  output smh64_pkg::dp_sts_t              sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [smh64_pkg::WordW-1:0]     hash_o
);

  logic [smh64_pkg::WordW-1:0]   seed_q;
  logic [smh64_pkg::WordW-1:0]   hash_q;
  logic [smh64_pkg::WordW-1:0]   key_q;
  logic [smh64_pkg::MsgLenW-1:0] len_q;
  logic                          full_q;
  logic                          nbz_q;
  logic                          last_q;
  logic [smh64_pkg::WordW-1:0]   acc_q;
  logic [smh64_pkg::WordW-1:0]   out_q;
  logic                          out_valid_q;

  logic [smh64_pkg::NbW-1:0]     in_nb;
  logic [smh64_pkg::WordW-1:0]   word_masked;
  logic [smh64_pkg::WordW-1:0]   op_a;
  logic [smh64_pkg::WordW-1:0]   op_b;
  logic [smh64_pkg::HalfW-1:0]   a_part;
  logic [smh64_pkg::HalfW-1:0]   b_part;
  logic [smh64_pkg::WordW-1:0]   prod;
  logic [smh64_pkg::WordW-1:0]   acc_sum;
  logic [smh64_pkg::WordW-1:0]   key_mix;
  logic [smh64_pkg::WordW-1:0]   hash_mix;
  logic [smh64_pkg::WordW-1:0]   fin_mix;

  // byte count saturates at a full word; bytes above the count are cleared
  assign in_nb = (valid_bytes_i > smh64_pkg::FullBytes) ? smh64_pkg::FullBytes
                                                        : valid_bytes_i;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word_masked[8*i +: 8] = (smh64_pkg::NbW'(i) < in_nb) ? data_word_i[8*i +: 8]
                                                          : 8'h00;
    end
  end

  // operand selection per phase; operands hold still during the three steps
  always_comb begin
    case (cmd_i.phase)
      smh64_pkg::PhInit: begin
        op_a = {{(smh64_pkg::WordW - smh64_pkg::MsgLenW){1'b0}}, len_q};
        op_b = smh64_pkg::Golden;
      end
      smh64_pkg::PhKey: begin
        op_a = key_q;
        op_b = smh64_pkg::MixC1;
      end
      smh64_pkg::PhHash: begin
        op_a = hash_q;
        op_b = smh64_pkg::MixC2;
      end
      default: begin
        op_a = hash_q ^ (hash_q >> smh64_pkg::ShiftMix);
        op_b = smh64_pkg::MixC1;
      end
    endcase
  end

  // one 32x32 partial product a step, the cross terms land in the upper half
  assign a_part  = (cmd_i.step == smh64_pkg::StepHL) ? op_a[63:32] : op_a[31:0];
  assign b_part  = (cmd_i.step == smh64_pkg::StepLH) ? op_b[63:32] : op_b[31:0];
  assign prod    = {32'h0, a_part} * {32'h0, b_part};
  assign acc_sum = acc_q + {prod[31:0], 32'h0};

  // write-back mixes, from the completed product
  assign key_mix  = full_q ? (acc_sum ^ (acc_sum >> smh64_pkg::ShiftMix)) : acc_sum;
  assign hash_mix = full_q ? {acc_sum[32:0], acc_sum[63:33]} : acc_sum;
  assign fin_mix  = acc_sum ^ (acc_sum >> smh64_pkg::ShiftMix);

  // control state: seed and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (cmd_i.mul_en && cmd_i.step == smh64_pkg::StepHL &&
          cmd_i.phase == smh64_pkg::PhFin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= word_masked;
      len_q  <= message_length_i & smh64_pkg::LenMask;
      full_q <= (in_nb == smh64_pkg::FullBytes);
      nbz_q  <= (in_nb == '0);
      last_q <= last_word_i;
    end
    if (cmd_i.mul_en) begin
      acc_q <= (cmd_i.step == smh64_pkg::StepLL) ? prod : acc_sum;
      if (cmd_i.step == smh64_pkg::StepHL) begin
        case (cmd_i.phase)
          smh64_pkg::PhInit: hash_q <= seed_q ^ acc_sum;
          smh64_pkg::PhKey:  hash_q <= hash_q ^ key_mix;
          smh64_pkg::PhHash: hash_q <= hash_mix;
          default: begin
            hash_q <= fin_mix;
            out_q  <= fin_mix;
          end
        endcase
      end
    end
  end

  assign sts_o.in_nbz    = (in_nb == '0);
  assign sts_o.in_last   = last_word_i;
  assign sts_o.nbz       = nbz_q;
  assign sts_o.last      = last_q;
  assign sts_o.out_valid = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign hash_o      = out_q;

endmodule

// File: rtl/core/smh64_ctrl.sv
// Controller of the hash block: sequences the multiplies of each word and
// tracks whether a message is in progress. Depends on smh64_pkg.
`timescale 1ns / 1ps

module smh64_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  smh64_pkg::dp_sts_t sts_i,
  output smh64_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SInit = 3'd1;
  localparam logic [2:0] SKey  = 3'd2;
  localparam logic [2:0] SHash = 3'd3;
  localparam logic [2:0] SFin  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] step_q, step_d;
  logic       mid_q, mid_d;
  logic       run;
  logic [2:0] after_mul;

  // state after the current multiply finishes
  always_comb begin
    case (state_q)
      SInit:   after_mul = !sts_i.nbz ? SKey : (sts_i.last ? SFin : SIdle);
      SKey:    after_mul = SHash;
      SHash:   after_mul = sts_i.last ? SFin : SIdle;
      default: after_mul = SIdle;
    endcase
  end

  // finaliser waits for a free result register before its first step
  assign run = !(state_q == SFin && step_q == smh64_pkg::StepLL && sts_i.out_valid);

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    mid_d        = mid_q;
    in_ready_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.mul_en = 1'b0;
    cmd_o.step   = step_q;
    case (state_q)
      SInit:   cmd_o.phase = smh64_pkg::PhInit;
      SKey:    cmd_o.phase = smh64_pkg::PhKey;
      SHash:   cmd_o.phase = smh64_pkg::PhHash;
      SFin:    cmd_o.phase = smh64_pkg::PhFin;
      default: cmd_o.phase = smh64_pkg::PhInit;
    endcase

    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          mid_d      = !sts_i.in_last;
          if (!mid_q) begin
            state_d = SInit;
          end else if (!sts_i.in_nbz) begin
            state_d = SKey;
          end else if (sts_i.in_last) begin
            state_d = SFin;
          end
        end
      end
      SInit, SKey, SHash, SFin: begin
        if (run) begin
          cmd_o.mul_en = 1'b1;
          if (step_q == smh64_pkg::StepHL) begin
            step_d  = smh64_pkg::StepLL;
            state_d = after_mul;
          end else begin
            step_d = step_q + 2'd1;
          end
        end
      end
      default: begin
        state_d = SIdle;
        step_d  = smh64_pkg::StepLL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      step_q  <= smh64_pkg::StepLL;
      mid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      mid_q   <= mid_d;
    end
  end

endmodule
